@@ hdl/slphd_pkg.sv @@
// Shared types, constants and lookup functions for the spectrum level peak-hold block.
package slphd_pkg;

  localparam int NUM_BINS_DEFAULT = 128;

  localparam int BIN_W    = 7;
  localparam int MAG_W    = 8;
  localparam int VAL_W    = 20;
  localparam int FRAC_W   = 12;
  localparam int SEL_W    = 3;
  localparam int FACTOR_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FALLOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FALLOFF  = 2'd1;

  // Reset values of the selectors.
  localparam logic [SEL_W-1:0] LEVEL_SEL_RESET = 3'd2;
  localparam logic [SEL_W-1:0] PEAK_SEL_RESET  = 3'd1;

  // Peak speed after a jump: 0.01 in Q8.12.
  localparam logic [VAL_W-1:0] START_SPEED = 20'd41;
  localparam logic [VAL_W-1:0] VAL_MAX     = 20'hFFFFF;

  // Per-bin state as stored in memory.
  typedef struct packed {
    logic [VAL_W-1:0] speed;
    logic [VAL_W-1:0] peak;
    logic [VAL_W-1:0] level;
  } bin_state_t;

  localparam int STATE_W = $bits(bin_state_t);

  // One result transaction waiting in the output queue.
  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [VAL_W-1:0] level;
    logic [VAL_W-1:0] peak;
  } result_t;

  // Level decay per update in Q8.12; selector codes above four act as four.
  function automatic logic [VAL_W-1:0] level_decay(input logic [SEL_W-1:0] sel);
    logic [VAL_W-1:0] d;
    case (sel)
      3'd0:    d = 20'd1393;
      3'd1:    d = 20'd2048;
      3'd2:    d = 20'd4096;
      3'd3:    d = 20'd5325;
      default: d = 20'd6554;
    endcase
    return d;
  endfunction

  // Peak speed growth factor in Q1.8; selector codes above four act as four.
  function automatic logic [FACTOR_W-1:0] growth_factor(input logic [SEL_W-1:0] sel);
    logic [FACTOR_W-1:0] f;
    case (sel)
      3'd0:    f = 9'd307;
      3'd1:    f = 9'd333;
      3'd2:    f = 9'd358;
      3'd3:    f = 9'd384;
      default: f = 9'd410;
    endcase
    return f;
  endfunction

endpackage

@@ hdl/slphd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module slphd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port returns the old contents on a same-address collision.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/spectrum_level_peak_hold_decay.sv @@
// Spectrum level smoother with per-bin peak hold and accelerating peak falloff.
//
// Usage: each input transaction carries a bin index and an 8-bit magnitude and
// produces exactly one result transaction with the bin index, the updated level
// and the updated peak marker, both unsigned Q8.12. Bins at or beyond NUM_BINS
// leave the state untouched and report zero level and peak.
// The configuration channel writes the two falloff selectors (index 0: level
// decay, index 1: peak speed growth); other indexes are ignored. It is always
// ready and should only be written while no transaction is in flight.
// The result passes through the read stage register into the result queue,
// whose non-empty state drives out_valid.
// Throughput: one transaction per cycle while the result queue has room, set by
// the single read-modify-write of the bin state memory; a write from the previous
// cycle is forwarded when the next transaction hits the same bin.
// A three-entry result queue sits at the output, so input is taken while
// results wait; when the receiver stalls the queue fills and in_ready drops.
// Reset clears the per-bin valid flags, so every bin reads as zero, and loads
// the selectors with decay 1.0 and growth 1.3; no memory clearing pass is run.
module spectrum_level_peak_hold_decay
  import slphd_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BIN_W-1:0]      bin_index,
  input  logic [MAG_W-1:0]      magnitude,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BIN_W-1:0]      bin_out,
  output logic [VAL_W-1:0]      level_value,
  output logic [VAL_W-1:0]      peak_value
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [BIN_W+1:0] BIN_LIMIT = (BIN_W + 2)'(NUM_BINS);
  localparam int QDEPTH = 3;
  localparam logic [1:0] QLAST = 2'(QDEPTH - 1);

  logic [SEL_W-1:0] level_sel;
  logic [SEL_W-1:0] peak_sel;

  logic             in_fire;
  logic [AW-1:0]    rd_addr;

  logic             s1_valid;
  logic             s1_in_range;
  logic [BIN_W-1:0] s1_bin;
  logic [MAG_W-1:0] s1_mag;
  logic [AW-1:0]    s1_addr;

  logic [NUM_BINS-1:0] bin_vld;
  logic                fwd_valid;
  logic [AW-1:0]       fwd_addr;
  bin_state_t          fwd_data;

  logic [STATE_W-1:0] ram_rdata;
  bin_state_t         cur;
  bin_state_t         upd;
  logic               wr_en;

  logic [VAL_W-1:0]   mag_q;
  logic [VAL_W-1:0]   decay;
  logic [VAL_W-1:0]   lvl_dec;
  logic [VAL_W-1:0]   lvl_new;
  logic               rise;
  logic               jump;
  logic [VAL_W-1:0]   pk_sub;
  logic [VAL_W-1:0]   pk_fall;
  logic [VAL_W+FACTOR_W-1:0] spd_prod;
  logic [VAL_W-1:0]   spd_grown;

  result_t    queue [QDEPTH];
  result_t    s1_result;
  logic [1:0] q_wr;
  logic [1:0] q_rd;
  logic [1:0] q_count;
  logic       q_push;
  logic       q_pop;

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_sel <= LEVEL_SEL_RESET;
      peak_sel  <= PEAK_SEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LEVEL_FALLOFF) begin
        level_sel <= cfg_data;
      end else if (cfg_index == CFG_PEAK_FALLOFF) begin
        peak_sel <= cfg_data;
      end
    end
  end

  // Input is taken while the queue has room for every transaction in flight.
  assign in_ready = ({1'b0, q_count} + 3'(s1_valid)) < 3'(QDEPTH);
  assign in_fire  = in_valid && in_ready;
  assign rd_addr  = AW'(bin_index);

  // Read stage: the memory read is issued as the transaction is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_bin      <= bin_index;
      s1_mag      <= magnitude;
      s1_addr     <= rd_addr;
      s1_in_range <= ({2'b00, bin_index} < BIN_LIMIT);
    end
  end

  slphd_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_BINS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (upd),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Current bin state: forwarded last write, memory data, or zero if never written.
  always_comb begin
    if (fwd_valid && (fwd_addr == s1_addr)) begin
      cur = fwd_data;
    end else if (bin_vld[s1_addr]) begin
      cur = bin_state_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  // Level update: rise at once, otherwise decay toward zero.
  assign mag_q   = {s1_mag, {FRAC_W{1'b0}}};
  assign rise    = mag_q > cur.level;
  assign decay   = level_decay(level_sel);
  assign lvl_dec = (cur.level > decay) ? (cur.level - decay) : '0;
  assign lvl_new = rise ? mag_q : lvl_dec;
  assign jump    = rise && (mag_q > cur.peak);

  // Peak falloff: drop by the speed, never below the level; speed grows and saturates.
  assign pk_sub    = (cur.peak > cur.speed) ? (cur.peak - cur.speed) : '0;
  assign pk_fall   = (pk_sub < lvl_new) ? lvl_new : pk_sub;
  assign spd_prod  = cur.speed * growth_factor(peak_sel);
  assign spd_grown = spd_prod[VAL_W+FACTOR_W-1] ? VAL_MAX : spd_prod[VAL_W+FACTOR_W-2:8];

  always_comb begin
    upd.level = lvl_new;
    if (jump) begin
      upd.peak  = mag_q;
      upd.speed = START_SPEED;
    end else if (cur.peak != '0) begin
      upd.peak  = pk_fall;
      upd.speed = spd_grown;
    end else begin
      upd.peak  = cur.peak;
      upd.speed = cur.speed;
    end
  end

  assign wr_en = s1_valid && s1_in_range;

  // Bypass of the write just made, for a read issued in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= s1_addr;
      fwd_data <= upd;
    end
  end

  // Per-bin written flags stand in for clearing the memory at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_vld <= '0;
    end else if (wr_en) begin
      bin_vld[s1_addr] <= 1'b1;
    end
  end

  // Result of the transaction in the compute stage.
  always_comb begin
    s1_result.bin = s1_bin;
    if (s1_in_range) begin
      s1_result.level = upd.level;
      s1_result.peak  = upd.peak;
    end else begin
      s1_result.level = '0;
      s1_result.peak  = '0;
    end
  end

  // Output queue.
  assign q_push = s1_valid;
  assign q_pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (q_push) begin
        q_wr <= (q_wr == QLAST) ? 2'd0 : (q_wr + 2'd1);
      end
      if (q_pop) begin
        q_rd <= (q_rd == QLAST) ? 2'd0 : (q_rd + 2'd1);
      end
      if (q_push && !q_pop) begin
        q_count <= q_count + 2'd1;
      end else if (!q_push && q_pop) begin
        q_count <= q_count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      queue[q_wr] <= s1_result;
    end
  end

  assign out_valid   = (q_count != 2'd0);
  assign bin_out     = queue[q_rd].bin;
  assign level_value = queue[q_rd].level;
  assign peak_value  = queue[q_rd].peak;

endmodule

@@ test/slphd_checker.sv @@
// Checker for the spectrum level peak-hold block: predicts every bin update and compares results.
`timescale 1ns / 100ps

module slphd_checker
  import slphd_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [BIN_W-1:0]      bin_index,
  input  logic [MAG_W-1:0]      magnitude,

  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [BIN_W-1:0]      bin_out,
  input  logic [VAL_W-1:0]      level_value,
  input  logic [VAL_W-1:0]      peak_value,

  output int                    fail_count,
  output int                    pending
);

  // Shadow copy of the per-bin state and of the two selectors.
  logic [VAL_W-1:0] level_mem [NUM_BINS];
  logic [VAL_W-1:0] peak_mem  [NUM_BINS];
  logic [VAL_W-1:0] speed_mem [NUM_BINS];
  logic [SEL_W-1:0] level_sel;
  logic [SEL_W-1:0] peak_sel;

  // Bin updates that the block still owes, oldest first.
  result_t bin_updates_q [$];

  // Level decay per update in Q8.12; codes above four behave as four.
  function automatic logic [VAL_W-1:0] decay_amount(input logic [SEL_W-1:0] sel);
    logic [VAL_W-1:0] amount;
    if (sel == 3'd0) amount = 20'd1393;       // 0.34
    else if (sel == 3'd1) amount = 20'd2048;  // 0.5
    else if (sel == 3'd2) amount = 20'd4096;  // 1.0
    else if (sel == 3'd3) amount = 20'd5325;  // 1.3
    else amount = 20'd6554;                   // 1.6
    return amount;
  endfunction

  // Peak speed growth factor in Q1.8; codes above four behave as four.
  function automatic logic [FACTOR_W-1:0] speed_factor(input logic [SEL_W-1:0] sel);
    logic [FACTOR_W-1:0] factor;
    if (sel == 3'd0) factor = 9'd307;         // 1.2
    else if (sel == 3'd1) factor = 9'd333;    // 1.3
    else if (sel == 3'd2) factor = 9'd358;    // 1.4
    else if (sel == 3'd3) factor = 9'd384;    // 1.5
    else factor = 9'd410;                     // 1.6
    return factor;
  endfunction

  // Applies one magnitude to its bin and returns the update the block should report.
  function automatic result_t advance_bin(input logic [BIN_W-1:0] bin,
                                          input logic [MAG_W-1:0] mag);
    result_t                        upd;
    logic [VAL_W-1:0]               lvl;
    logic [VAL_W-1:0]               pk;
    logic [VAL_W-1:0]               spd;
    logic [VAL_W-1:0]               mag_q;
    logic [VAL_W-1:0]               decay;
    logic [VAL_W+FACTOR_W-1:0]      grown;
    logic                           jump;
    logic                           fall;
    upd.bin   = bin;
    upd.level = '0;
    upd.peak  = '0;
    if (bin >= NUM_BINS) return upd;

    lvl   = level_mem[bin];
    pk    = peak_mem[bin];
    spd   = speed_mem[bin];
    mag_q = {mag, {FRAC_W{1'b0}}};
    jump  = 1'b0;
    fall  = 1'b0;

    // A rise is taken at once; anything else decays the level toward zero.
    if (mag_q > lvl) begin
      lvl = mag_q;
      if (lvl > pk) jump = 1'b1;
      else fall = (pk != '0);
    end else begin
      decay = decay_amount(level_sel);
      if (lvl != '0) lvl = (lvl > decay) ? lvl - decay : '0;
      fall = (pk != '0);
    end

    // The peak either follows a jump or falls by its speed, which then grows.
    if (jump) begin
      pk  = lvl;
      spd = START_SPEED;
    end else if (fall) begin
      pk    = (pk > spd) ? pk - spd : '0;
      grown = ({{FACTOR_W{1'b0}}, spd} * {{VAL_W{1'b0}}, speed_factor(peak_sel)}) >> 8;
      spd   = (grown > VAL_MAX) ? VAL_MAX : grown[VAL_W-1:0];
      if (pk < lvl) pk = lvl;
    end

    level_mem[bin] = lvl;
    peak_mem[bin]  = pk;
    speed_mem[bin] = spd;
    upd.level = lvl;
    upd.peak  = pk;
    return upd;
  endfunction

  // Follow every transaction on the three channels at the clock edge.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        level_mem[i] = '0;
        peak_mem[i]  = '0;
        speed_mem[i] = '0;
      end
      level_sel = LEVEL_SEL_RESET;
      peak_sel  = PEAK_SEL_RESET;
      bin_updates_q.delete();
      fail_count = 0;
    end else begin
      // Selector writes; other indexes are ignored by the block.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEVEL_FALLOFF: level_sel = cfg_data;
          CFG_PEAK_FALLOFF:  peak_sel  = cfg_data;
          default: ;
        endcase
      end

      // Compare each result transaction with the oldest expected update.
      if (out_valid && out_ready) begin
        if (bin_updates_q.size() == 0) begin
          $error("unexpected result transaction: bin_out %0d level_value %0d peak_value %0d",
                 bin_out, level_value, peak_value);
          fail_count++;
        end else begin
          want = bin_updates_q.pop_front();
          if (bin_out !== want.bin) begin
            $error("bin_out: expected %0d, actual %0d", want.bin, bin_out);
            fail_count++;
          end
          if (level_value !== want.level) begin
            $error("level_value: expected %0d, actual %0d", want.level, level_value);
            fail_count++;
          end
          if (peak_value !== want.peak) begin
            $error("peak_value: expected %0d, actual %0d", want.peak, peak_value);
            fail_count++;
          end
        end
      end

      if (in_valid && in_ready) bin_updates_q.push_back(advance_bin(bin_index, magnitude));
    end
    pending = bin_updates_q.size();
  end

endmodule

@@ test/tb_top.sv @@
// Top of the spectrum level peak-hold testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import slphd_pkg::*;

  // Indexes that hold no register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Selector settings for the random phases, three bits per phase, phase 0 lowest.
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 135;
  localparam logic [3*PHASES-1:0] LEVEL_PLAN = {3'd6, 3'd5, 3'd3, 3'd1, 3'd7, 3'd2, 3'd4, 3'd0};
  localparam logic [3*PHASES-1:0] PEAK_PLAN  = {3'd6, 3'd7, 3'd2, 3'd3, 3'd5, 3'd1, 3'd0, 3'd4};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BIN_W-1:0]      bin_index = '0;
  logic [MAG_W-1:0]      magnitude = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BIN_W-1:0]      bin_out;
  logic [VAL_W-1:0]      level_value;
  logic [VAL_W-1:0]      peak_value;

  logic                  steady = 1'b0;
  int                    fail_total;
  int                    pending_results;

  spectrum_level_peak_hold_decay i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .bin_index   (bin_index),
    .magnitude   (magnitude),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bin_out     (bin_out),
    .level_value (level_value),
    .peak_value  (peak_value)
  );

  slphd_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .bin_index   (bin_index),
    .magnitude   (magnitude),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bin_out     (bin_out),
    .level_value (level_value),
    .peak_value  (peak_value),
    .fail_count  (fail_total),
    .pending     (pending_results)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  // The receiver stalls about a third of the time, except during the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  // Offers one input transaction, with an occasional gap first, and waits for acceptance.
  task automatic send_item(input logic [BIN_W-1:0] bin, input logic [MAG_W-1:0] mag);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    bin_index <= bin;
    magnitude <= mag;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops sending and waits until every expected bin update has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One configuration transaction; cfg_valid stays high for a following write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes both selectors plus one or two spare indexes, then releases the channel.
  task automatic program_selectors(input logic [SEL_W-1:0] lvl_sel,
                                   input logic [SEL_W-1:0] pk_sel);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) cfg_write(CFG_SPARE_HI, junk);
    cfg_write(CFG_LEVEL_FALLOFF, lvl_sel);
    cfg_write(CFG_PEAK_FALLOFF, pk_sel);
    cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, ~junk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [BIN_W-1:0] bin_a;
    logic [BIN_W-1:0] bin_b;
    logic [MAG_W-1:0] mag;
    int               sent;
    int               run_len;
    int               kind;
    int               roll;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset selectors: full-scale jump, decay, top bin,
    // an empty bin, and a rise that stays under the falling peak.
    send_item(7'd0, 8'd255);
    send_item(7'd0, 8'd0);
    send_item(7'd0, 8'd0);
    send_item(7'd127, 8'd1);
    send_item(7'd127, 8'd0);
    send_item(7'd5, 8'd0);
    send_item(7'd1, 8'd100);
    send_item(7'd1, 8'd0);
    send_item(7'd1, 8'd0);
    send_item(7'd1, 8'd99);
    send_item(7'd64, 8'd170);
    drain();

    // Slowest decay and fastest growth: a small peak falls until it clamps at zero,
    // then stays there with its speed frozen.
    program_selectors(3'd0, 3'd4);
    send_item(7'd85, 8'd1);
    repeat (11) send_item(7'd85, 8'd0);
    send_item(7'd85, 8'd0);
    drain();

    // Random phases, each under its own selector setting.
    for (int phase = 0; phase < PHASES; phase++) begin
      program_selectors(LEVEL_PLAN[3*phase +: 3], PEAK_PLAN[3*phase +: 3]);
      steady <= (phase == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          // One bin hit hard and then left to decay, with the odd smaller rise.
          bin_a   = BIN_W'($urandom_range(0, 127));
          mag     = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'd255;
          run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(5, 30);
          send_item(bin_a, mag);
          for (int k = 0; k < run_len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) send_item(bin_a, 8'd0);
            else if (roll < 90) send_item(bin_a, 8'($urandom_range(0, mag)));
            else send_item(bin_a, 8'($urandom_range(0, 255)));
          end
          sent += run_len + 1;
        end else if (kind < 8) begin
          // Two bins interleaved, so that neighboring updates alternate.
          bin_a   = BIN_W'($urandom_range(0, 127));
          bin_b   = BIN_W'($urandom_range(0, 127));
          run_len = $urandom_range(4, 20);
          for (int k = 0; k < run_len; k++) begin
            send_item(k[0] ? bin_b : bin_a, 8'($urandom_range(0, 255)));
          end
          sent += run_len;
        end else begin
          // Plain noise over all bins and magnitudes.
          run_len = $urandom_range(1, 10);
          for (int k = 0; k < run_len; k++) begin
            send_item(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
          end
          sent += run_len;
        end
      end
      drain();
    end

    if (fail_total == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
